// ===== design/streaming_mean_variance_defines.svh =====
// assertion macros for the streaming mean and variance block
// used by the checker module, no other dependencies
`ifndef STREAMING_MEAN_VARIANCE_DEFINES_SVH
`define STREAMING_MEAN_VARIANCE_DEFINES_SVH

// same-cycle implication
`define SMV_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SMV_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== design/smv_pkg.sv =====
// shared widths, state codes and control structs for the mean and variance block
// no dependencies
`timescale 1ns / 1ps

package smv_pkg;

  localparam int SAMPLE_W  = 24;
  localparam int VAR_W     = 47;
  localparam int COUNT_W   = 17;
  localparam int SUM_W     = 41;
  localparam int SUMSQ_W   = 63;
  localparam int MAX_COUNT = 65536;
  localparam int SQ_W      = 2 * SAMPLE_W;
  localparam int NUM_W     = 2 * SUM_W;
  localparam int DEN_W     = 2 * COUNT_W;
  localparam int STEP_W    = $clog2(NUM_W + 2);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ACCUM,
    ST_PREP,
    ST_MEAN_DIV,
    ST_DEN_MUL,
    ST_SUMSQ_MUL,
    ST_SUM_MUL,
    ST_VAR_DIV,
    ST_RESULT
  } state_t;

  typedef enum logic [2:0] {
    ALU_IDLE,
    ALU_MUL_LOAD,
    ALU_MUL_STEP,
    ALU_DIV_LOAD,
    ALU_SUB_LOAD,
    ALU_DIV_STEP
  } alu_op_t;

  typedef struct packed {
    logic capture;
    logic square;
    logic add;
    logic clear;
  } acc_cmd_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    logic [SUMSQ_W-1:0]      sumsq;
    logic [COUNT_W-1:0]      count;
    logic                    ovf;
  } acc_state_t;

  typedef struct packed {
    alu_op_t          op;
    logic [NUM_W-1:0] a;
    logic [SUM_W-1:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic [NUM_W-1:0] acc;
    logic [VAR_W-1:0] quo;
    logic             sat;
    logic             neg;
  } alu_res_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] mean_value;
    logic [VAR_W-1:0]           variance_value;
    logic                       mean_ok;
    logic                       variance_ok;
    logic [COUNT_W-1:0]         valid_count;
    logic                       overflowed;
  } result_t;

endpackage

// ===== design/smv_stream_if.sv =====
// valid/ready channel interfaces for sample requests and result requests
// depends on smv_pkg
`timescale 1ns / 1ps

interface smv_in_if;
  import smv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       is_missing;
  logic                       last;

  modport source (output valid, sample, is_missing, last, input ready);
  modport sink (input valid, sample, is_missing, last, output ready);
endinterface

interface smv_out_if;
  import smv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] mean_value;
  logic [VAR_W-1:0]           variance_value;
  logic                       mean_ok;
  logic                       variance_ok;
  logic [COUNT_W-1:0]         valid_count;
  logic                       overflowed;

  modport source (output valid, mean_value, variance_value, mean_ok, variance_ok,
                  valid_count, overflowed, input ready);
  modport sink (input valid, mean_value, variance_value, mean_ok, variance_ok,
                valid_count, overflowed, output ready);
endinterface

// ===== design/streaming_mean_variance.sv =====
// streaming mean and unbiased variance; each sample request steps through capture, square
// and accumulate; after a last request the shared bit-serial multiply/divide unit runs the mean
// division if any sample is valid, then three products and variance division for two or more
// one result register: the next request is taken while a result waits
// synchronous active-high reset clears the sequencer, accumulators and output valid
`timescale 1ns / 1ps

module streaming_mean_variance (
  input  logic      clk,
  input  logic      rst,
  smv_in_if.sink    in_stream,
  smv_out_if.source out_stream
);
  import smv_pkg::*;

  acc_cmd_t   acc_cmd;
  acc_state_t acc_st;
  alu_cmd_t   alu_cmd;
  alu_res_t   alu_res;
  result_t    result;
  logic       in_ready;
  logic       out_valid;

  smv_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cmd        (acc_cmd),
    .sample     (in_stream.sample),
    .is_missing (in_stream.is_missing),
    .st         (acc_st)
  );

  smv_alu u_alu (
    .clk (clk),
    .cmd (alu_cmd),
    .res (alu_res)
  );

  smv_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_stream.valid),
    .in_last   (in_stream.last),
    .in_ready  (in_ready),
    .acc_cmd   (acc_cmd),
    .acc_st    (acc_st),
    .alu_cmd   (alu_cmd),
    .alu_res   (alu_res),
    .out_ready (out_stream.ready),
    .out_valid (out_valid),
    .result    (result)
  );

  assign in_stream.ready           = in_ready;
  assign out_stream.valid          = out_valid;
  assign out_stream.mean_value     = result.mean_value;
  assign out_stream.variance_value = result.variance_value;
  assign out_stream.mean_ok        = result.mean_ok;
  assign out_stream.variance_ok    = result.variance_ok;
  assign out_stream.valid_count    = result.valid_count;
  assign out_stream.overflowed     = result.overflowed;

endmodule

// ===== design/smv_accum.sv =====
// running sum, sum of squares, valid count and overflow flag
// squares the held sample on the square command and accumulates it on the add command; depends on smv_pkg
`timescale 1ns / 1ps

module smv_accum (
  input  logic                               clk,
  input  logic                               rst,
  input  smv_pkg::acc_cmd_t                  cmd,
  input  logic signed [smv_pkg::SAMPLE_W-1:0] sample,
  input  logic                               is_missing,
  output smv_pkg::acc_state_t                st
);
  import smv_pkg::*;

  logic signed [SAMPLE_W-1:0] sample_r;
  logic                       missing_r;
  logic [SAMPLE_W-1:0]        mag;
  logic [SQ_W-1:0]            sq_r;
  logic signed [SUM_W-1:0]    sum;
  logic [SUMSQ_W-1:0]         sumsq;
  logic [COUNT_W-1:0]         count;
  logic                       ovf;

  assign mag = sample_r[SAMPLE_W-1] ? $unsigned(-sample_r) : $unsigned(sample_r);

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_r  <= sample;
      missing_r <= is_missing;
    end
    if (cmd.square) begin
      sq_r <= mag * mag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      sum   <= '0;
      sumsq <= '0;
      count <= '0;
      ovf   <= 1'b0;
    end else if (cmd.add && !missing_r) begin
      if (count >= COUNT_W'(MAX_COUNT)) begin
        ovf <= 1'b1;
      end else begin
        sum   <= sum + SUM_W'(sample_r);
        sumsq <= sumsq + SUMSQ_W'(sq_r);
        count <= count + 1'b1;
      end
    end
  end

  always_comb begin
    st.sum   = sum;
    st.sumsq = sumsq;
    st.count = count;
    st.ovf   = ovf;
  end

endmodule

// ===== design/smv_alu.sv =====
// shared shift-add multiplier and restoring divider, one bit per cycle
// quotient saturation tracked as bits leave the top; depends on smv_pkg
`timescale 1ns / 1ps

module smv_alu (
  input  logic              clk,
  input  smv_pkg::alu_cmd_t cmd,
  output smv_pkg::alu_res_t res
);
  import smv_pkg::*;

  logic [NUM_W-1:0] acc;
  logic [NUM_W-1:0] work;
  logic [SUM_W-1:0] mplier;
  logic [DEN_W-1:0] rem;
  logic [DEN_W-1:0] den;
  logic [VAR_W-1:0] quo;
  logic             sat;
  logic             neg;
  logic [DEN_W:0]   rem_try;
  logic [DEN_W:0]   rem_sub;
  logic             fits;
  logic [NUM_W:0]   diff;

  assign rem_try = {rem, work[NUM_W-1]};
  assign fits    = rem_try >= {1'b0, den};
  assign rem_sub = rem_try - {1'b0, den};
  assign diff    = {1'b0, cmd.a} - {1'b0, acc};

  always_ff @(posedge clk) begin
    case (cmd.op)
      ALU_IDLE: begin
      end
      ALU_MUL_LOAD: begin
        acc    <= '0;
        work   <= cmd.a;
        mplier <= cmd.b;
      end
      ALU_MUL_STEP: begin
        if (mplier[0]) begin
          acc <= acc + work;
        end
        work   <= work << 1;
        mplier <= mplier >> 1;
      end
      ALU_DIV_LOAD: begin
        work <= cmd.a;
        den  <= cmd.b[DEN_W-1:0];
        rem  <= '0;
        quo  <= '0;
        sat  <= 1'b0;
        neg  <= 1'b0;
      end
      ALU_SUB_LOAD: begin
        work <= diff[NUM_W-1:0];
        neg  <= diff[NUM_W];
        den  <= cmd.b[DEN_W-1:0];
        rem  <= '0;
        quo  <= '0;
        sat  <= 1'b0;
      end
      ALU_DIV_STEP: begin
        work <= work << 1;
        rem  <= fits ? rem_sub[DEN_W-1:0] : rem_try[DEN_W-1:0];
        quo  <= {quo[VAR_W-2:0], fits};
        sat  <= sat | quo[VAR_W-1];
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.acc = acc;
    res.quo = quo;
    res.sat = sat;
    res.neg = neg;
  end

endmodule

// ===== design/smv_ctrl.sv =====
// sequencer: accumulate steps, then mean division (one or more samples), three products
// and variance division (two or more); holds the result register; depends on smv_pkg
`timescale 1ns / 1ps

module smv_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_last,
  output logic                in_ready,
  output smv_pkg::acc_cmd_t   acc_cmd,
  input  smv_pkg::acc_state_t acc_st,
  output smv_pkg::alu_cmd_t   alu_cmd,
  input  smv_pkg::alu_res_t   alu_res,
  input  logic                out_ready,
  output logic                out_valid,
  output smv_pkg::result_t    result
);
  import smv_pkg::*;

  state_t                     state;
  state_t                     state_next;
  logic [STEP_W-1:0]          step;
  logic [STEP_W-1:0]          step_next;
  logic                       last_r;
  logic signed [SAMPLE_W-1:0] mean_r;
  logic [VAR_W-1:0]           var_r;
  logic [DEN_W-1:0]           den_r;
  logic [NUM_W-1:0]           prod_r;
  logic                       sum_neg;
  logic [SUM_W-1:0]           sum_mag;
  logic [SUM_W-1:0]           count_ext;
  logic [SAMPLE_W-1:0]        quo_low;
  logic                       accept;
  logic                       out_free;
  logic                       div_end;
  logic                       mul_end;

  assign accept    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign sum_neg   = acc_st.sum[SUM_W-1];
  assign sum_mag   = sum_neg ? $unsigned(-acc_st.sum) : $unsigned(acc_st.sum);
  assign count_ext = SUM_W'(acc_st.count);
  assign quo_low   = alu_res.quo[SAMPLE_W-1:0];
  assign div_end   = (step == STEP_W'(NUM_W + 1));
  assign mul_end   = (step == STEP_W'(SUM_W + 1));

  always_comb begin
    state_next = state;
    step_next  = step;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        state_next = last_r ? ST_PREP : ST_IDLE;
      end
      ST_PREP: begin
        step_next  = '0;
        state_next = (acc_st.count == '0) ? ST_RESULT : ST_MEAN_DIV;
      end
      ST_MEAN_DIV: begin
        if (div_end) begin
          step_next  = '0;
          state_next = (acc_st.count >= COUNT_W'(2)) ? ST_DEN_MUL : ST_RESULT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_DEN_MUL: begin
        if (mul_end) begin
          step_next  = '0;
          state_next = ST_SUMSQ_MUL;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SUMSQ_MUL: begin
        if (mul_end) begin
          step_next  = '0;
          state_next = ST_SUM_MUL;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_SUM_MUL: begin
        if (mul_end) begin
          step_next  = '0;
          state_next = ST_VAR_DIV;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_VAR_DIV: begin
        if (div_end) begin
          step_next  = '0;
          state_next = ST_RESULT;
        end else begin
          step_next = step + 1'b1;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_ready        = (state == ST_IDLE);
    acc_cmd.capture = accept;
    acc_cmd.square  = (state == ST_SQUARE);
    acc_cmd.add     = (state == ST_ACCUM);
    acc_cmd.clear   = (state == ST_RESULT) && out_free;
    alu_cmd.op      = ALU_IDLE;
    alu_cmd.a       = '0;
    alu_cmd.b       = '0;
    case (state)
      ST_MEAN_DIV: begin
        if (step == '0) begin
          alu_cmd.op = ALU_DIV_LOAD;
          alu_cmd.a  = NUM_W'(sum_mag);
          alu_cmd.b  = count_ext;
        end else if (!div_end) begin
          alu_cmd.op = ALU_DIV_STEP;
        end
      end
      ST_DEN_MUL: begin
        if (step == '0) begin
          alu_cmd.op = ALU_MUL_LOAD;
          alu_cmd.a  = NUM_W'(acc_st.count - 1'b1);
          alu_cmd.b  = count_ext;
        end else if (!mul_end) begin
          alu_cmd.op = ALU_MUL_STEP;
        end
      end
      ST_SUMSQ_MUL: begin
        if (step == '0) begin
          alu_cmd.op = ALU_MUL_LOAD;
          alu_cmd.a  = NUM_W'(acc_st.sumsq);
          alu_cmd.b  = count_ext;
        end else if (!mul_end) begin
          alu_cmd.op = ALU_MUL_STEP;
        end
      end
      ST_SUM_MUL: begin
        if (step == '0) begin
          alu_cmd.op = ALU_MUL_LOAD;
          alu_cmd.a  = NUM_W'(sum_mag);
          alu_cmd.b  = sum_mag;
        end else if (!mul_end) begin
          alu_cmd.op = ALU_MUL_STEP;
        end
      end
      ST_VAR_DIV: begin
        if (step == '0) begin
          alu_cmd.op = ALU_SUB_LOAD;
          alu_cmd.a  = prod_r;
          alu_cmd.b  = SUM_W'(den_r);
        end else if (!div_end) begin
          alu_cmd.op = ALU_DIV_STEP;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if ((state == ST_RESULT) && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r <= in_last;
    end
    if (state == ST_PREP) begin
      mean_r <= '0;
      var_r  <= '0;
    end
    if ((state == ST_MEAN_DIV) && div_end) begin
      mean_r <= sum_neg ? $signed(-quo_low) : $signed(quo_low);
    end
    if ((state == ST_DEN_MUL) && mul_end) begin
      den_r <= alu_res.acc[DEN_W-1:0];
    end
    if ((state == ST_SUMSQ_MUL) && mul_end) begin
      prod_r <= alu_res.acc;
    end
    if ((state == ST_VAR_DIV) && div_end) begin
      var_r <= alu_res.neg ? '0 : (alu_res.sat ? '1 : alu_res.quo);
    end
    if ((state == ST_RESULT) && out_free) begin
      result.mean_value     <= mean_r;
      result.variance_value <= var_r;
      result.mean_ok        <= (acc_st.count != '0);
      result.variance_ok    <= (acc_st.count >= COUNT_W'(2));
      result.valid_count    <= acc_st.count;
      result.overflowed     <= acc_st.ovf;
    end
  end

endmodule

// ===== design/smv_checker.sv =====
// port-level checks for streaming_mean_variance, attached by bind
// depends on smv_pkg and streaming_mean_variance_defines.svh
`timescale 1ns / 1ps
`include "streaming_mean_variance_defines.svh"

module smv_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               in_valid,
  input logic                               in_ready,
  input logic                               out_valid,
  input logic                               out_ready,
  input logic signed [smv_pkg::SAMPLE_W-1:0] mean_value,
  input logic [smv_pkg::VAR_W-1:0]          variance_value,
  input logic                               mean_ok,
  input logic                               variance_ok,
  input logic [smv_pkg::COUNT_W-1:0]        valid_count,
  input logic                               overflowed
);
  import smv_pkg::*;

  `SMV_ASSERT_NXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(mean_value) && $stable(variance_value) && $stable(valid_count), "result changed while stalled")
  `SMV_ASSERT_NXT(a_busy_after_req, clk, rst, in_valid && in_ready, !in_ready, "ready right after a request")
  `SMV_ASSERT_IMP(a_ok_flags, clk, rst, out_valid, (mean_ok == (valid_count != '0)) && (variance_ok == (valid_count >= COUNT_W'(2))), "ok flags disagree with count")
  `SMV_ASSERT_IMP(a_var_zero, clk, rst, out_valid && !variance_ok, variance_value == '0, "variance nonzero without two samples")
  `SMV_ASSERT_IMP(a_ovf_count, clk, rst, out_valid && overflowed, valid_count == COUNT_W'(MAX_COUNT), "overflow below full count")

endmodule

bind streaming_mean_variance smv_checker u_smv_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_stream.valid),
  .in_ready       (in_stream.ready),
  .out_valid      (out_stream.valid),
  .out_ready      (out_stream.ready),
  .mean_value     (out_stream.mean_value),
  .variance_value (out_stream.variance_value),
  .mean_ok        (out_stream.mean_ok),
  .variance_ok    (out_stream.variance_ok),
  .valid_count    (out_stream.valid_count),
  .overflowed     (out_stream.overflowed)
);
